// File: rtl/bsm_pkg.sv
// bsm_pkg: shared constants for the booth signed multiplier
// no dependencies; imported by the interfaces, the step stage and the top level
package bsm_pkg;

    // default operand width in bits
    localparam int unsigned BSM_WIDTH = 8;

endpackage : bsm_pkg

// File: rtl/bsm_if.sv
// bsm_if: valid/ready channels for operand items and product items
// depends on bsm_pkg for the default operand width

// operand channel: multiplicand and multiplier
interface bsm_in_if
    import bsm_pkg::*;
#(
    parameter int unsigned WIDTH = BSM_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] multiplicand;
    logic signed [WIDTH-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface : bsm_in_if

// result channel: full signed product
interface bsm_out_if
    import bsm_pkg::*;
#(
    parameter int unsigned WIDTH = BSM_WIDTH
);
    logic                      valid;
    logic                      ready;
    logic signed [2*WIDTH-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface : bsm_out_if

// File: rtl/booth_signed_multiplier.sv
// channel  | modport | payload                          | role
// ---------+---------+----------------------------------+------------------------
// i_in     | sink    | multiplicand, multiplier (WIDTH) | operand items in
// o_out    | source  | product (2*WIDTH)                | product items out
//
// one registered booth step per multiplier bit, WIDTH stages in a row, the last
// stage acting as the output register. a new item may enter every cycle unless
// a finished product stalls, so throughput is one product per cycle.
// while a finished product waits unaccepted the whole pipeline holds and
// i_in.ready is low; nothing is dropped or repeated.
// i_rst_n (synchronous, active low) clears every stage valid bit and holds i_in.ready low.
//
// booth_signed_multiplier: top level, chains WIDTH bsm_step stages
// depends on bsm_pkg, bsm_in_if, bsm_out_if and bsm_step
module booth_signed_multiplier
    import bsm_pkg::*;
#(
    parameter int unsigned WIDTH = BSM_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsm_in_if.sink    i_in,
    bsm_out_if.source o_out
);

    logic             w_en;
    logic             w_valid [0:WIDTH];
    logic [WIDTH:0]   w_acc   [0:WIDTH];
    logic [WIDTH-1:0] w_mpr   [0:WIDTH];
    logic             w_prev  [0:WIDTH];
    logic [WIDTH:0]   w_mcand [0:WIDTH];

    // whole pipeline advances unless a finished product is stalled
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en && i_rst_n;

    // stage zero inputs: cleared accumulator and previous bit, guarded multiplicand
    assign w_valid[0] = i_in.valid;
    assign w_acc[0]   = '0;
    assign w_mpr[0]   = i_in.multiplier;
    assign w_prev[0]  = 1'b0;
    assign w_mcand[0] = {i_in.multiplicand[WIDTH-1], i_in.multiplicand};

    // one booth step per multiplier bit
    for (genvar k = 0; k < WIDTH; k++) begin : g_step
        bsm_step #(
            .WIDTH(WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_acc   (w_acc[k]),
            .i_mpr   (w_mpr[k]),
            .i_prev  (w_prev[k]),
            .i_mcand (w_mcand[k]),
            .o_valid (w_valid[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_mpr   (w_mpr[k+1]),
            .o_prev  (w_prev[k+1]),
            .o_mcand (w_mcand[k+1])
        );
    end

    // product: low WIDTH bits of the accumulator over the shifted multiplier
    assign o_out.valid   = w_valid[WIDTH];
    assign o_out.product = {w_acc[WIDTH][WIDTH-1:0], w_mpr[WIDTH]};

endmodule : booth_signed_multiplier

// File: rtl/bsm_step.sv
// bsm_step: one registered radix-2 booth step (add/subtract, then arithmetic shift)
// depends on bsm_pkg for the default operand width
module bsm_step
    import bsm_pkg::*;
#(
    parameter int unsigned WIDTH = BSM_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH:0]   i_acc,
    input  logic [WIDTH-1:0] i_mpr,
    input  logic             i_prev,
    input  logic [WIDTH:0]   i_mcand,
    output logic             o_valid,
    output logic [WIDTH:0]   o_acc,
    output logic [WIDTH-1:0] o_mpr,
    output logic             o_prev,
    output logic [WIDTH:0]   o_mcand
);

    typedef enum logic [1:0] {
        OP_KEEP,
        OP_ADD,
        OP_SUB
    } t_op;

    t_op              w_op;
    logic [WIDTH:0]   w_sum;
    logic             r_valid;
    logic [WIDTH:0]   r_acc;
    logic [WIDTH-1:0] r_mpr;
    logic             r_prev;
    logic [WIDTH:0]   r_mcand;
    logic [WIDTH:0]   n_acc;
    logic [WIDTH-1:0] n_mpr;

    // booth pair decode on current low bit and the bit shifted out before
    always_comb begin
        case ({i_mpr[0], i_prev})
            2'b10:   w_op = OP_SUB;
            2'b01:   w_op = OP_ADD;
            default: w_op = OP_KEEP;
        endcase
    end

    // guarded accumulator update
    always_comb begin
        case (w_op)
            OP_ADD:  w_sum = i_acc + i_mcand;
            OP_SUB:  w_sum = i_acc - i_mcand;
            default: w_sum = i_acc;
        endcase
    end

    // arithmetic right shift of accumulator and multiplier as one word
    assign n_acc = {w_sum[WIDTH], w_sum[WIDTH:1]};
    assign n_mpr = {w_sum[0], i_mpr[WIDTH-1:1]};

    // valid bit, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc   <= n_acc;
            r_mpr   <= n_mpr;
            r_prev  <= i_mpr[0];
            r_mcand <= i_mcand;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_mpr   = r_mpr;
    assign o_prev  = r_prev;
    assign o_mcand = r_mcand;

endmodule : bsm_step

// File: rtl/bsm_checker.sv
// bsm_checker: port-level checks on the booth signed multiplier
// depends on bsm_pkg; bound to booth_signed_multiplier below
module bsm_checker
    import bsm_pkg::*;
#(
    parameter int unsigned WIDTH = BSM_WIDTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [2*WIDTH-1:0] i_product
);

    // a stalled product holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_product))
        else $error("stalled product changed or vanished");

    // operands are taken exactly when the output side is free to move
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    // no product straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("product valid right after reset");

    // for WIDTH == 1 only: with no item entering and no product shown before, no product appears
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_out_valid) && !$past(i_in_valid) && $past(i_rst_n)
        && !$past(i_out_valid, 2) && !$past(i_in_valid, 2) && $past(i_rst_n, 2)
        && (WIDTH == 1) |-> !i_out_valid)
        else $error("product appeared with no item");

endmodule : bsm_checker

bind booth_signed_multiplier bsm_checker #(
    .WIDTH(WIDTH)
) u_bsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_product   (o_out.product)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for booth_signed_multiplier, directed table then random items
// depends on bsm_pkg, bsm_in_if, bsm_out_if and the booth_signed_multiplier top level
module tb;
    import bsm_pkg::*;

    localparam int unsigned W          = BSM_WIDTH;
    localparam int          RAND_ITEMS = 1900;
    localparam int          CALM_TAIL  = 150;
    localparam int          DRAIN      = 4 * W;
    localparam int          CYCLE_CAP  = 600000;

    // one row of operand stimulus, with an optional hand-typed product
    typedef struct {
        logic signed [W-1:0]   mcand;
        logic signed [W-1:0]   mplier;
        logic                  typed;
        logic signed [2*W-1:0] prod;
    } t_op_row;

    // one product waiting to come out, with its operands for reporting
    typedef struct {
        logic signed [W-1:0]   mcand;
        logic signed [W-1:0]   mplier;
        logic signed [2*W-1:0] prod;
    } t_prod_entry;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  src_valid  = 1'b0;
    logic signed [W-1:0]   src_mcand  = '0;
    logic signed [W-1:0]   src_mplier = '0;
    logic                  snk_ready  = 1'b0;

    t_op_row     op_queue[$];
    t_prod_entry product_queue[$];
    t_op_row     held_row;

    int src_gap         = 0;
    int snk_gap         = 0;
    int total_items     = 0;
    int accepted_items  = 0;
    int checked_prods   = 0;
    int typed_checked   = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    bsm_in_if  #(.WIDTH(W)) in_bus();
    bsm_out_if #(.WIDTH(W)) out_bus();

    assign in_bus.valid        = src_valid;
    assign in_bus.multiplicand = src_mcand;
    assign in_bus.multiplier   = src_mplier;
    assign out_bus.ready       = snk_ready;

    booth_signed_multiplier #(.WIDTH(W)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // clock, 4 ns period
    always #2 i_clk = ~i_clk;

    // radix-2 booth product with a guard bit on the accumulator
    function automatic logic signed [2*W-1:0] booth_product(
        input logic signed [W-1:0] mcand,
        input logic signed [W-1:0] mplier
    );
        logic [W:0]   acc;
        logic [W:0]   mc_ext;
        logic [W-1:0] q;
        logic         prev;
        acc    = '0;
        mc_ext = {mcand[W-1], mcand};
        q      = mplier;
        prev   = 1'b0;
        for (int k = 0; k < W; k++) begin
            case ({q[0], prev})
                2'b10: acc = acc - mc_ext;
                2'b01: acc = acc + mc_ext;
                default: ;
            endcase
            prev = q[0];
            q    = {acc[0], q[W-1:1]};
            acc  = {acc[W], acc[W:1]};
        end
        return {acc[W-1:0], q};
    endfunction

    // random operand, leaning on the corners now and then
    function automatic logic signed [W-1:0] pick_operand();
        logic signed [W-1:0] corner [5];
        corner[0] = {1'b1, {(W-1){1'b0}}};
        corner[1] = '1;
        corner[2] = '0;
        corner[3] = W'(1);
        corner[4] = {1'b0, {(W-1){1'b1}}};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 4)];
        return W'($urandom());
    endfunction

    task automatic add_row(input int m, input int q, input logic typed, input int p);
        t_op_row r;
        r.mcand  = W'(m);
        r.mplier = W'(q);
        r.typed  = typed;
        r.prod   = (2*W)'(p);
        op_queue.push_back(r);
    endtask

    // operand source: bursts of idling, none near the end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && in_bus.ready) begin
                t_prod_entry e;
                e.mcand  = held_row.mcand;
                e.mplier = held_row.mplier;
                e.prod   = held_row.typed ? held_row.prod
                                          : booth_product(held_row.mcand, held_row.mplier);
                product_queue.push_back(e);
                accepted_items++;
            end
            if (!src_valid || in_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    src_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    held_row = op_queue.pop_front();
                    src_mcand  <= held_row.mcand;
                    src_mplier <= held_row.mplier;
                    src_valid  <= 1'b1;
                    if (op_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 19);
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // product sink: ready drops in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
        end else begin
            if (snk_gap > 0) begin
                snk_gap--;
                snk_ready <= 1'b0;
            end else begin
                snk_ready <= 1'b1;
                if (accepted_items < total_items - CALM_TAIL && $urandom_range(0, 4) == 0)
                    snk_gap = $urandom_range(1, 19);
            end
        end
    end

    // product check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && snk_ready) begin
            if (product_queue.size() == 0) begin
                $display("%0t unexpected product: got %0d", $time, out_bus.product);
                error_count++;
            end else begin
                t_prod_entry e;
                e = product_queue.pop_front();
                if (out_bus.product !== e.prod) begin
                    $display("%0t product mismatch for %0d * %0d: expected %0d, got %0d",
                             $time, e.mcand, e.mplier, e.prod, out_bus.product);
                    error_count++;
                end
                checked_prods++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout with %0d products outstanding", $time, product_queue.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus table, random items and end of run
    initial begin
        // corners with products read off directly
        add_row(   0,    0, 1'b1,      0);
        add_row( 127,  127, 1'b1,  16129);
        add_row(-128, -128, 1'b1,  16384);
        add_row(-128,  127, 1'b1, -16256);
        add_row( 127, -128, 1'b1, -16256);
        add_row(-128,    1, 1'b1,   -128);
        add_row(   1, -128, 1'b1,   -128);
        add_row(  -1,   -1, 1'b1,      1);
        add_row(-128,   -1, 1'b1,    128);
        add_row(  -1, -128, 1'b1,    128);
        add_row( 127,    0, 1'b1,      0);
        add_row(   0, -128, 1'b1,      0);
        add_row(   1,    1, 1'b1,      1);
        add_row(  -1,  127, 1'b1,   -127);
        // alternating and run-length multiplier patterns
        add_row(  85,  -86, 1'b0, 0);
        add_row( -86,   85, 1'b0, 0);
        add_row(-128,   85, 1'b0, 0);
        add_row(-128,  -86, 1'b0, 0);
        add_row(  37,  -16, 1'b0, 0);
        add_row( -53,   15, 1'b0, 0);
        add_row(  37,  -19, 1'b0, 0);
        add_row(-100,   99, 1'b0, 0);
        for (int i = 0; i < 14; i++)
            typed_checked++;
        for (int i = 0; i < RAND_ITEMS; i++)
            add_row(pick_operand(), pick_operand(), 1'b0, 0);
        total_items = op_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every item went in and every product came back
        while (accepted_items != total_items || product_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("run covered %0d operand items (%0d with hand-typed products)",
                 accepted_items, typed_checked);
        $display("%0d products compared, %0d errors", checked_prods, error_count);
        if (error_count == 0 && product_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule : tb

// File: filelist.f
rtl/bsm_pkg.sv
rtl/bsm_if.sv
rtl/bsm_step.sv
rtl/booth_signed_multiplier.sv
rtl/bsm_checker.sv
tb/sv/tb.sv
